/* src/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the serial packet deframer
// Frame constants, checksum character helper and the transaction carried
// from the framing front end to the peer-state back end.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int PACKET_BYTES = 12;
	localparam int FRESH_W      = 4;

	localparam logic [7:0] FRAME_START    = 8'h02;
	localparam logic [7:0] FRAME_END      = 8'h03;
	localparam logic [3:0] NIBBLE_MASK    = 4'hf;
	localparam logic [7:0] CHAR_0         = 8'h30;  // '0'
	localparam logic [7:0] CHAR_1         = 8'h31;
	localparam logic [7:0] CHAR_2         = 8'h32;
	localparam logic [7:0] CHAR_3         = 8'h33;
	localparam logic [7:0] CHAR_4         = 8'h34;
	localparam logic [7:0] CHAR_5         = 8'h35;
	localparam logic [7:0] CHAR_6         = 8'h36;
	localparam logic [7:0] CHAR_8         = 8'h38;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'h57;  // 'a' minus ten

	localparam logic [2:0] PEER_CLEAR = 3'd0;
	localparam logic [2:0] PEER_3     = 3'd3;
	localparam logic [2:0] PEER_4     = 3'd4;
	localparam logic [2:0] PEER_6     = 3'd6;

	// Priority action decoded from the station bytes
	typedef enum logic [1:0] {
		OP_KEEP = 2'd0,
		OP_SET  = 2'd1,
		OP_SET3 = 2'd2,
		OP_SET4 = 2'd3
	} prio_op_t;

	// One framed packet on its way to the back end
	typedef struct packed {
		logic [15:0] receiver_id;
		logic [15:0] sender_id;
		logic [7:0]  command_code;
		logic [15:0] station_code;
		logic [15:0] sub_number;
		logic        checksum_ok;
		prio_op_t    op;
		logic [2:0]  op_value;
		logic        clear_peer;
	} pkt_t;

	// Lowercase hex ASCII character of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CHAR_0 + {4'b0, nib};
		end
		return HEX_ALPHA_BASE + {4'b0, nib};
	endfunction

endpackage

/* src/spd_front.sv */
// ----------------------------------------------------------------------------
// spd_front: byte window and frame classification
// Shifts each received byte into the window, detects framed packets of
// fresh bytes, checks the checksum character and decodes the priority rule.
// ----------------------------------------------------------------------------
module spd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          checksum_check,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    rx_byte,
	input  logic          block_start,
	input  logic          q_full,
	output logic          push,
	output spd_pkg::pkt_t push_pkt
);

	localparam int LAST = spd_pkg::PACKET_BYTES - 1;

	logic [7:0]                  win_q [spd_pkg::PACKET_BYTES];
	logic [7:0]                  win_next [spd_pkg::PACKET_BYTES];
	logic [spd_pkg::FRESH_W-1:0] fresh_q;
	logic [spd_pkg::FRESH_W-1:0] fresh_base;
	logic [spd_pkg::FRESH_W-1:0] fresh_inc;
	logic                        pend_q;
	logic                        accept;
	logic                        framed;
	logic [3:0]                  nib_sum;
	logic                        sum_ok;
	logic                        take;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Form the window as it stands after this byte
	always_comb begin
		for (int i = 0; i < LAST; i++) begin
			win_next[i] = win_q[i+1];
		end
		win_next[LAST] = rx_byte;
	end

	// Count fresh bytes, restarting at a block start
	always_comb begin
		fresh_base = block_start ? '0 : fresh_q;
		if (fresh_base < spd_pkg::FRESH_W'(spd_pkg::PACKET_BYTES)) begin
			fresh_inc = fresh_base + 1'b1;
		end else begin
			fresh_inc = fresh_base;
		end
	end

	// Sum low nibbles of bytes 1..9; only the low nibble of the total matters
	always_comb begin
		nib_sum = '0;
		for (int k = 1; k <= 9; k++) begin
			nib_sum = nib_sum + (win_next[k][3:0] & spd_pkg::NIBBLE_MASK);
		end
	end

	assign sum_ok = (win_next[10] == spd_pkg::hex_char(nib_sum));
	assign framed = (fresh_inc == spd_pkg::FRESH_W'(spd_pkg::PACKET_BYTES)) &&
	                (win_next[0] == spd_pkg::FRAME_START) &&
	                (win_next[LAST] == spd_pkg::FRAME_END);
	assign take   = framed && (!checksum_check || sum_ok);
	assign push   = accept && take;

	// Decode the priority action and gather the reported fields
	always_comb begin
		push_pkt.op       = spd_pkg::OP_KEEP;
		push_pkt.op_value = win_next[6][2:0];
		if (win_next[7] == spd_pkg::CHAR_0 && win_next[8] == spd_pkg::CHAR_0 &&
		    win_next[9] == spd_pkg::CHAR_8) begin
			if (win_next[6] inside {spd_pkg::CHAR_0, spd_pkg::CHAR_1, spd_pkg::CHAR_2,
			                        spd_pkg::CHAR_5, spd_pkg::CHAR_6}) begin
				push_pkt.op = spd_pkg::OP_SET;
			end else if (win_next[6] == spd_pkg::CHAR_3) begin
				push_pkt.op = spd_pkg::OP_SET3;
			end else if (win_next[6] == spd_pkg::CHAR_4) begin
				push_pkt.op = spd_pkg::OP_SET4;
			end
		end
		push_pkt.receiver_id  = {win_next[1], win_next[2]};
		push_pkt.sender_id    = {win_next[3], win_next[4]};
		push_pkt.command_code = win_next[5];
		push_pkt.station_code = {win_next[6], win_next[7]};
		push_pkt.sub_number   = {win_next[8], win_next[9]};
		push_pkt.checksum_ok  = sum_ok;
		push_pkt.clear_peer   = pend_q || block_start;
	end

	// Advance the window; its contents count only once fresh
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < spd_pkg::PACKET_BYTES; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

	// Track fresh bytes and a block start not yet seen by the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '0;
			pend_q  <= 1'b0;
		end else if (accept) begin
			fresh_q <= take ? '0 : fresh_inc;
			if (take) begin
				pend_q <= 1'b0;
			end else if (block_start) begin
				pend_q <= 1'b1;
			end
		end
	end

endmodule

/* src/spd_queue.sv */
// ----------------------------------------------------------------------------
// spd_queue: packet queue between front and back end
// Small first-in first-out buffer; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module spd_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  spd_pkg::pkt_t push_pkt,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output spd_pkg::pkt_t head_pkt
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	spd_pkg::pkt_t    mem_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_pkt   = mem_q[rd_ptr_q];

	// Store pushed transactions
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pkt;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow push");

endmodule

/* src/spd_back.sv */
// ----------------------------------------------------------------------------
// spd_back: peer-state rule and result register
// Applies each packet's priority rule in order and holds the result until
// the output transaction completes.
// ----------------------------------------------------------------------------
module spd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  spd_pkg::pkt_t head_pkt,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [15:0]   receiver_id,
	output logic [15:0]   sender_id,
	output logic [7:0]    command_code,
	output logic [15:0]   station_code,
	output logic [15:0]   sub_number,
	output logic          checksum_ok,
	output logic [2:0]    peer_state
);

	logic       out_valid_q;
	logic [2:0] run_q;
	logic [2:0] base;
	logic [2:0] next_state;

	assign out_valid = out_valid_q;
	assign pop       = head_valid && (!out_valid_q || out_ready);

	// Apply the priority rule on top of the running state
	always_comb begin
		base = head_pkt.clear_peer ? spd_pkg::PEER_CLEAR : run_q;
		case (head_pkt.op)
			spd_pkg::OP_SET:  next_state = head_pkt.op_value;
			spd_pkg::OP_SET3: next_state = (base == spd_pkg::PEER_6) ? base : spd_pkg::PEER_3;
			spd_pkg::OP_SET4: next_state = (base == spd_pkg::PEER_3 || base == spd_pkg::PEER_6) ?
			                               base : spd_pkg::PEER_4;
			default:          next_state = base;
		endcase
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (pop) begin
			receiver_id  <= head_pkt.receiver_id;
			sender_id    <= head_pkt.sender_id;
			command_code <= head_pkt.command_code;
			station_code <= head_pkt.station_code;
			sub_number   <= head_pkt.sub_number;
			checksum_ok  <= head_pkt.checksum_ok;
			peer_state   <= next_state;
		end
	end

	// Hold output valid and the running peer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_q       <= spd_pkg::PEER_CLEAR;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			run_q       <= next_state;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* src/serial_packet_deframer.sv */
// ----------------------------------------------------------------------------
// serial_packet_deframer: framed packet extraction from a serial byte stream
// Accepts one received byte per transaction and reports each framed packet.
// ----------------------------------------------------------------------------
// Throughput is one byte per clock cycle while in_ready is high, set by the
// 12-byte shift window that takes a byte and classifies the frame in the
// same cycle. Each result passes through a QUEUE_DEPTH-entry queue and the
// back end's result register; in_ready drops only while that queue is full
// because results are not being taken. checksum_check is to be written by
// the user through cfg_we/cfg_wdata while the block is idle (not enforced).
module serial_packet_deframer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        block_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] receiver_id,
	output logic [15:0] sender_id,
	output logic [7:0]  command_code,
	output logic [15:0] station_code,
	output logic [15:0] sub_number,
	output logic        checksum_ok,
	output logic [2:0]  peer_state
);

	logic          checksum_check_q;
	logic          q_full;
	logic          push;
	spd_pkg::pkt_t push_pkt;
	logic          pop;
	logic          head_valid;
	spd_pkg::pkt_t head_pkt;

	// Hold the checksum enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_check_q <= 1'b0;
		end else if (cfg_we) begin
			checksum_check_q <= cfg_wdata;
		end
	end

	spd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.checksum_check (checksum_check_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.block_start    (block_start),
		.q_full         (q_full),
		.push           (push),
		.push_pkt       (push_pkt)
	);

	spd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_pkt   (push_pkt),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_pkt   (head_pkt)
	);

	spd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_pkt     (head_pkt),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.receiver_id  (receiver_id),
		.sender_id    (sender_id),
		.command_code (command_code),
		.station_code (station_code),
		.sub_number   (sub_number),
		.checksum_ok  (checksum_ok),
		.peer_state   (peer_state)
	);

endmodule

/* tb/serial_packet_deframer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_packet_deframer_tb: self-checking bench for the packet deframer
// Streams bytes into the deframer and predicts every framed packet from its
// own copy of the byte window. The stream holds well-formed packets, bad
// checksums, noise, cut-off frames and block restarts. Both handshakes stall
// at random. Every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module serial_packet_deframer_tb;

	localparam logic [7:0] CHAR_A       = 8'h61;  // 'a'
	localparam logic [7:0] CHAR_7       = 8'h37;  // not a station with a rule
	localparam int         LONG_HOLD    = 400;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         PHASE_BYTES  = 270;

	// One decoded packet as it leaves the block
	typedef struct {
		logic [15:0] receiver_id;
		logic [15:0] sender_id;
		logic [7:0]  command_code;
		logic [15:0] station_code;
		logic [15:0] sub_number;
		logic        checksum_ok;
		logic [2:0]  peer_state;
	} frame_fields_t;

	// Predict framed packets and hold them until the block reports them
	class deframe_scoreboard;
		logic [7:0]    window [spd_pkg::PACKET_BYTES];
		int unsigned   fresh;
		logic [2:0]    peer;
		bit            check_en;
		frame_fields_t expected_q [$];
		int unsigned   errors;

		function new();
			clear_block();
			check_en = 1'b0;
			errors   = 0;
		endfunction

		function void clear_block();
			foreach (window[i]) window[i] = 8'h00;
			fresh = 0;
			peer  = spd_pkg::PEER_CLEAR;
		endfunction

		// Lowercase hex character of the low nibble of a byte sum
		function logic [7:0] sum_char(logic [7:0] sum);
			if (sum[3:0] < 4'd10) begin
				return spd_pkg::CHAR_0 + {4'b0, sum[3:0]};
			end
			return CHAR_A + {4'b0, sum[3:0]} - 8'd10;
		endfunction

		// Update the peer state from the station bytes
		function void apply_station_rule();
			if (window[7] != spd_pkg::CHAR_0 || window[8] != spd_pkg::CHAR_0 ||
					window[9] != spd_pkg::CHAR_8) begin
				return;
			end
			case (window[6])
				spd_pkg::CHAR_0, spd_pkg::CHAR_1, spd_pkg::CHAR_2, spd_pkg::CHAR_5,
				spd_pkg::CHAR_6: peer = window[6][2:0];
				spd_pkg::CHAR_3: if (peer != spd_pkg::PEER_6) peer = spd_pkg::PEER_3;
				spd_pkg::CHAR_4: begin
					if (peer != spd_pkg::PEER_3 && peer != spd_pkg::PEER_6) begin
						peer = spd_pkg::PEER_4;
					end
				end
				default: ;
			endcase
		endfunction

		// Shift one accepted byte in and queue the packet it closes, if any
		function void note_byte(logic [7:0] b, logic bs);
			logic [7:0]    sum;
			logic          ok;
			frame_fields_t f;
			if (bs) clear_block();
			for (int i = 0; i < spd_pkg::PACKET_BYTES - 1; i++) window[i] = window[i + 1];
			window[spd_pkg::PACKET_BYTES - 1] = b;
			if (fresh < spd_pkg::PACKET_BYTES) fresh++;
			if (fresh < spd_pkg::PACKET_BYTES || window[0] != spd_pkg::FRAME_START ||
					window[spd_pkg::PACKET_BYTES - 1] != spd_pkg::FRAME_END) begin
				return;
			end
			sum = 8'h00;
			for (int k = 1; k <= 9; k++) sum += window[k];
			ok = (window[10] == sum_char(sum));
			if (check_en && !ok) return;
			apply_station_rule();
			fresh = 0;
			f.receiver_id  = {window[1], window[2]};
			f.sender_id    = {window[3], window[4]};
			f.command_code = window[5];
			f.station_code = {window[6], window[7]};
			f.sub_number   = {window[8], window[9]};
			f.checksum_ok  = ok;
			f.peer_state   = peer;
			expected_q.push_back(f);
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(frame_fields_t got);
			frame_fields_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual receiver_id %h",
					$time, got.receiver_id);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			check_field("receiver_id", want.receiver_id, got.receiver_id);
			check_field("sender_id", want.sender_id, got.sender_id);
			check_field("command_code", 16'(want.command_code), 16'(got.command_code));
			check_field("station_code", want.station_code, got.station_code);
			check_field("sub_number", want.sub_number, got.sub_number);
			check_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
			check_field("peer_state", 16'(want.peer_state), 16'(got.peer_state));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        block_start;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] receiver_id;
	logic [15:0] sender_id;
	logic [7:0]  command_code;
	logic [15:0] station_code;
	logic [15:0] sub_number;
	logic        checksum_ok;
	logic [2:0]  peer_state;

	deframe_scoreboard sb;
	bit                sender_burst;
	bit                hold_req;
	int unsigned       bytes_sent;
	logic [7:0]        pkt [spd_pkg::PACKET_BYTES];

	serial_packet_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.block_start  (block_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.receiver_id  (receiver_id),
		.sender_id    (sender_id),
		.command_code (command_code),
		.station_code (station_code),
		.sub_number   (sub_number),
		.checksum_ok  (checksum_ok),
		.peer_state   (peer_state)
	);

	// Run the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("serial_packet_deframer_tb: done, errors");
		$finish;
	end

	// Offer one byte transaction and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic bs);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		rx_byte     <= b;
		block_start <= bs;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_byte(b, bs);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted packet has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_check(input logic v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we      <= 1'b0;
		sb.check_en = v;
	endtask

	// Fill packet bytes 1..9, optionally with a station that drives the rule
	task automatic fill_body(input bit rule);
		for (int i = 1; i <= 9; i++) pkt[i] = 8'($urandom_range(0, 255));
		if (rule) begin
			pkt[6] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
				: spd_pkg::CHAR_0 + 8'($urandom_range(0, 7));
			pkt[7] = spd_pkg::CHAR_0;
			pkt[8] = spd_pkg::CHAR_0;
			pkt[9] = spd_pkg::CHAR_8;
			// break the rule pattern now and then
			if ($urandom_range(0, 5) == 0) pkt[7 + $urandom_range(0, 2)] = 8'($urandom_range(0, 255));
		end
	endtask

	// Add start, checksum character and end bytes
	task automatic seal_packet(input bit good);
		logic [7:0] s;
		s = 8'h00;
		for (int i = 1; i <= 9; i++) s += pkt[i];
		pkt[0]  = spd_pkg::FRAME_START;
		pkt[10] = sb.sum_char(s);
		if (!good) pkt[10] ^= 8'($urandom_range(1, 255));
		pkt[11] = spd_pkg::FRAME_END;
	endtask

	task automatic send_packet(input bit new_block);
		for (int i = 0; i < spd_pkg::PACKET_BYTES; i++) send_byte(pkt[i], new_block && i == 0);
	endtask

	// Mix packets, bad checksums, noise and broken frames
	task automatic random_traffic(input int unsigned n_bytes);
		int unsigned stop;
		int          kind;
		int          cut;
		logic [7:0]  nb;
		stop = bytes_sent + n_bytes;
		while (bytes_sent < stop) begin
			sender_burst = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				fill_body(1'($urandom_range(0, 1)));
				seal_packet(1'b1);
				send_packet($urandom_range(0, 7) == 0);
			end else if (kind < 67) begin
				fill_body(1'($urandom_range(0, 1)));
				seal_packet(1'b0);
				send_packet(1'b0);
			end else if (kind < 82) begin
				repeat ($urandom_range(1, 8)) begin
					nb = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 3) == 0) begin
						nb = $urandom_range(0, 1) ? spd_pkg::FRAME_START : spd_pkg::FRAME_END;
					end
					send_byte(nb, $urandom_range(0, 15) == 0);
				end
			end else if (kind < 92) begin
				// cut the frame short and restart the block
				fill_body(1'b0);
				seal_packet(1'b1);
				cut = $urandom_range(1, 11);
				for (int i = 0; i < cut; i++) send_byte(pkt[i], 1'b0);
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				// frame with a wrong end byte
				fill_body(1'b1);
				seal_packet(1'b1);
				pkt[11] = 8'($urandom_range(4, 255));
				send_packet(1'b0);
			end
		end
		sender_burst = 1'b0;
	endtask

	// Take results with random stalls and one long hold-off
	initial begin
		int            gap;
		int            fast_left;
		frame_fields_t got;
		out_ready = 1'b0;
		fast_left = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (fast_left > 0) begin
					gap = 0;
					fast_left--;
				end else begin
					gap = $urandom_range(0, 9);
					if ($urandom_range(0, 19) == 0) fast_left = $urandom_range(10, 30);
				end
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.receiver_id  = receiver_id;
			got.sender_id    = sender_id;
			got.command_code = command_code;
			got.station_code = station_code;
			got.sub_number   = sub_number;
			got.checksum_ok  = checksum_ok;
			got.peer_state   = peer_state;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	// Main sequence
	initial begin
		logic [7:0] s;
		logic [7:0] stations [7];
		sb           = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		in_valid     = 1'b0;
		rx_byte      = 8'h00;
		block_start  = 1'b0;
		hold_req     = 1'b0;
		sender_burst = 1'b0;
		bytes_sent   = 0;
		stations     = '{spd_pkg::CHAR_6, spd_pkg::CHAR_4, spd_pkg::CHAR_3, spd_pkg::CHAR_0,
		                 spd_pkg::CHAR_4, spd_pkg::CHAR_3, spd_pkg::CHAR_4};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_check(1'b0);

		// block start on a plain byte, then an all-ones body
		send_byte(8'h00, 1'b1);
		for (int i = 1; i <= 9; i++) pkt[i] = 8'hff;
		seal_packet(1'b1);
		send_packet(1'b0);
		// all-zero body opening a new block
		for (int i = 1; i <= 9; i++) pkt[i] = 8'h00;
		seal_packet(1'b1);
		send_packet(1'b1);
		// bad checksum still reported while checking is off
		fill_body(1'b0);
		seal_packet(1'b0);
		send_packet(1'b0);
		// walk the station rule through its blocked cases
		foreach (stations[i]) begin
			fill_body(1'b1);
			pkt[6] = stations[i];
			pkt[7] = spd_pkg::CHAR_0;
			pkt[8] = spd_pkg::CHAR_0;
			pkt[9] = spd_pkg::CHAR_8;
			seal_packet(1'b1);
			send_packet(1'b0);
		end
		// bytes of a taken packet must not frame again
		fill_body(1'b0);
		pkt[1] = spd_pkg::FRAME_START;
		seal_packet(1'b1);
		send_packet(1'b0);
		send_byte(spd_pkg::FRAME_END, 1'b0);
		// restart the block in the middle of a packet, which also clears peer state
		fill_body(1'b1);
		seal_packet(1'b1);
		for (int i = 0; i < 6; i++) send_byte(pkt[i], 1'b0);
		pkt[6] = CHAR_7;
		pkt[7] = spd_pkg::CHAR_0;
		pkt[8] = spd_pkg::CHAR_0;
		pkt[9] = spd_pkg::CHAR_8;
		seal_packet(1'b1);
		send_packet(1'b1);

		write_check(1'b1);

		// rejected packet slides on and frames again two bytes later
		fill_body(1'b0);
		pkt[2] = spd_pkg::FRAME_START;
		seal_packet(1'b0);
		send_packet(1'b0);
		s = 8'h00;
		for (int i = 3; i < spd_pkg::PACKET_BYTES; i++) s += pkt[i];
		send_byte(sb.sum_char(s), 1'b0);
		send_byte(spd_pkg::FRAME_END, 1'b0);
		fill_body(1'b1);
		seal_packet(1'b1);
		send_packet(1'b0);

		random_traffic(PHASE_BYTES);

		// hold off the receiver while packets keep coming, so the input stalls
		hold_req     = 1'b1;
		sender_burst = 1'b1;
		repeat (8) begin
			fill_body(1'b1);
			seal_packet(1'b1);
			send_packet(1'b0);
		end
		sender_burst = 1'b0;
		drain();

		random_traffic(PHASE_BYTES);
		write_check(1'b0);
		random_traffic(PHASE_BYTES);
		write_check(1'b1);
		random_traffic(PHASE_BYTES / 2);
		write_check(1'b0);
		random_traffic(PHASE_BYTES / 2);
		drain();

		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("serial_packet_deframer_tb: done, clean");
		end else begin
			$display("serial_packet_deframer_tb: done, errors");
		end
		$finish;
	end

endmodule
